// File: rtl/core/midpoint_ellipse_rasterizer_core_defines.svh
// Assertion macros for the midpoint ellipse rasterizer core.
// Expects clk and rst_n in the scope of every use; no other dependencies.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only out of reset
`define MER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define MER_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MER_ASSERT(lbl, prop, msg)
`define MER_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/core/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer core.
// No dependencies.
package mer_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Input opcodes
  typedef enum logic [0:0] {
    OPC_LOAD = 1'b0,
    OPC_STEP = 1'b1
  } opc_t;

  // Datapath operations, one per cycle unless stalled
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_AA,
    OP_BB,
    OP_AAB2,
    OP_INIT,
    OP_XB,
    OP_YA,
    OP_CMP,
    OP_TXSQ,
    OP_T1,
    OP_TYSQ,
    OP_T2,
    OP_ENT,
    OP_R1,
    OP_R2
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AA,
    ST_BB,
    ST_AAB2,
    ST_INIT,
    ST_YA,
    ST_CMP,
    ST_TXSQ,
    ST_T1,
    ST_TYSQ,
    ST_T2,
    ST_ENT,
    ST_R1,
    ST_R2,
    ST_EMIT,
    ST_SPARE
  } ctrl_state_t;

  // Controller to datapath / output stage
  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } mer_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic r2;
    logic x_lt;
  } dp_sts_t;

endpackage

// File: rtl/core/mer_in_if.sv
// Input channel: valid/ready transaction carrying one load or step item.
// Depends on mer_pkg.
interface mer_in_if import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] corner_start_x;
  logic [COORD_BITS-1:0] corner_start_y;
  logic [COORD_BITS-1:0] corner_end_x;
  logic [COORD_BITS-1:0] corner_end_y;

  modport source (
    output valid, opcode, corner_start_x, corner_start_y, corner_end_x, corner_end_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, corner_start_x, corner_start_y, corner_end_x, corner_end_y,
    output ready
  );
endinterface

// File: rtl/core/mer_out_if.sv
// Result channel: valid/ready transaction carrying four mirrored points.
// Depends on mer_pkg.
interface mer_out_if import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point0_x;
  logic [COORD_BITS-1:0] point0_y;
  logic [COORD_BITS-1:0] point1_x;
  logic [COORD_BITS-1:0] point1_y;
  logic [COORD_BITS-1:0] point2_x;
  logic [COORD_BITS-1:0] point2_y;
  logic [COORD_BITS-1:0] point3_x;
  logic [COORD_BITS-1:0] point3_y;
  logic                  last;

  modport source (
    output valid, point0_x, point0_y, point1_x, point1_y,
           point2_x, point2_y, point3_x, point3_y, last,
    input  ready
  );
  modport sink (
    input  valid, point0_x, point0_y, point1_x, point1_y,
           point2_x, point2_y, point3_x, point3_y, last,
    output ready
  );
endinterface

// File: rtl/core/midpoint_ellipse_rasterizer_core.sv
// Channel   Dir  Moves
// in_ch     in   load (two corners) or step transaction
// out_ch    out  four mirrored points plus last flag
//
// A load runs setup states AA to INIT before its result; a step runs YA, CMP
// and R1 or R2, and the step entering region 2 adds TXSQ to ENT before R2.
// A finished result waits in the output register while the next item is taken.
// A step while no outline is active is accepted and produces nothing.
// Reset (rst_n, synchronous, active low) returns to idle with no outline active.
// Top level of the midpoint ellipse rasterizer; depends on mer_pkg, the channel
// interfaces, mer_ctrl and mer_dpath.
module midpoint_ellipse_rasterizer_core import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);

  mer_cmd_t              cmd;
  dp_sts_t               sts;
  logic                  in_ready;
  logic                  out_busy;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  logic                  pl;
  logic [COORD_BITS-1:0] p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  logic                  last_r;

  assign in_ch.ready = in_ready;
  assign out_busy    = out_valid_r && !out_ch.ready;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .out_busy  (out_busy),
    .cmd       (cmd)
  );

  mer_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (cmd.op),
    .corner_start_x (in_ch.corner_start_x),
    .corner_start_y (in_ch.corner_start_y),
    .corner_end_x   (in_ch.corner_end_x),
    .corner_end_y   (in_ch.corner_end_y),
    .sts            (sts),
    .point0_x       (p0x),
    .point0_y       (p0y),
    .point1_x       (p1x),
    .point1_y       (p1y),
    .point2_x       (p2x),
    .point2_y       (p2y),
    .point3_x       (p3x),
    .point3_y       (p3y),
    .last           (pl)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      p0x_r  <= p0x;
      p0y_r  <= p0y;
      p1x_r  <= p1x;
      p1y_r  <= p1y;
      p2x_r  <= p2x;
      p2y_r  <= p2y;
      p3x_r  <= p3x;
      p3y_r  <= p3y;
      last_r <= pl;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.point0_x = p0x_r;
  assign out_ch.point0_y = p0y_r;
  assign out_ch.point1_x = p1x_r;
  assign out_ch.point1_y = p1y_r;
  assign out_ch.point2_x = p2x_r;
  assign out_ch.point2_y = p2y_r;
  assign out_ch.point3_x = p3x_r;
  assign out_ch.point3_y = p3y_r;
  assign out_ch.last     = last_r;

endmodule

// File: rtl/core/mer_ctrl.sv
// Ellipse rasterizer sequencer: one datapath operation per cycle unless stalled.
// Depends on mer_pkg and the assertion macro header.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module mer_ctrl import mer_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_ready,
  input  dp_sts_t  sts,
  input  logic     out_busy,
  output mer_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        dispatch;
  logic        accept;
  logic        is_load;

  // Idle, or a finished result can move into the output register
  assign dispatch = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && !out_busy);
  assign in_ready = dispatch;
  assign accept   = in_valid && dispatch;
  assign is_load  = (in_opcode == OPC_LOAD);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_EMIT: begin
        if (dispatch) begin
          priority if (!accept) state_nxt = ST_IDLE;
          else if (is_load)     state_nxt = ST_AA;
          else if (sts.active)  state_nxt = ST_YA;
          else                  state_nxt = ST_IDLE;
        end
      end
      ST_AA:   state_nxt = ST_BB;
      ST_BB:   state_nxt = ST_AAB2;
      ST_AAB2: state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_EMIT;
      ST_YA:   state_nxt = ST_CMP;
      ST_CMP: begin
        priority if (sts.r2) state_nxt = ST_R2;
        else if (sts.x_lt)   state_nxt = ST_R1;
        else                 state_nxt = ST_TXSQ;
      end
      ST_TXSQ: state_nxt = ST_T1;
      ST_T1:   state_nxt = ST_TYSQ;
      ST_TYSQ: state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_ENT;
      ST_ENT:  state_nxt = ST_R2;
      ST_R1:   state_nxt = ST_EMIT;
      ST_R2:   state_nxt = ST_EMIT;
      ST_SPARE: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE, ST_EMIT: begin
        cmd.out_load = (state_r == ST_EMIT) && !out_busy;
        if (accept) begin
          priority if (is_load) cmd.op = OP_LOAD;
          else if (sts.active)  cmd.op = OP_XB;
          else                  cmd.op = OP_NONE;
        end
      end
      ST_AA:    cmd.op = OP_AA;
      ST_BB:    cmd.op = OP_BB;
      ST_AAB2:  cmd.op = OP_AAB2;
      ST_INIT:  cmd.op = OP_INIT;
      ST_YA:    cmd.op = OP_YA;
      ST_CMP:   cmd.op = OP_CMP;
      ST_TXSQ:  cmd.op = OP_TXSQ;
      ST_T1:    cmd.op = OP_T1;
      ST_TYSQ:  cmd.op = OP_TYSQ;
      ST_T2:    cmd.op = OP_T2;
      ST_ENT:   cmd.op = OP_ENT;
      ST_R1:    cmd.op = OP_R1;
      ST_R2:    cmd.op = OP_R2;
      ST_SPARE: cmd.op = OP_NONE;
    endcase
  end

  `MER_ASSERT_RST(a_rst_idle, !rst_n |=> (state_r == ST_IDLE), "reset left controller busy")
  `MER_ASSERT(a_load_seq, (accept && is_load) |=> (state_r == ST_AA), "load did not start setup")
  `MER_ASSERT(a_no_overrun, cmd.out_load |-> !out_busy, "result overwrote a waiting transaction")
  `MER_ASSERT(a_step_idle, (accept && !is_load && !sts.active) |=> (state_r == ST_IDLE), "step on idle outline started work")

endmodule

// File: rtl/core/mer_dpath.sv
// Datapath of the ellipse rasterizer: geometry registers, one shared multiplier,
// decision variable and point mirroring. Depends on mer_pkg and the macro header.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module mer_dpath import mer_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                op,
  input  logic [COORD_BITS-1:0] corner_start_x,
  input  logic [COORD_BITS-1:0] corner_start_y,
  input  logic [COORD_BITS-1:0] corner_end_x,
  input  logic [COORD_BITS-1:0] corner_end_y,
  output dp_sts_t               sts,
  output logic [COORD_BITS-1:0] point0_x,
  output logic [COORD_BITS-1:0] point0_y,
  output logic [COORD_BITS-1:0] point1_x,
  output logic [COORD_BITS-1:0] point1_y,
  output logic [COORD_BITS-1:0] point2_x,
  output logic [COORD_BITS-1:0] point2_y,
  output logic [COORD_BITS-1:0] point3_x,
  output logic [COORD_BITS-1:0] point3_y,
  output logic                  last
);

  localparam int N     = COORD_BITS;
  // decision value is exact below 64 bits, modulo 2^64 beyond
  localparam int DEC_W = (4 * COORD_BITS + 8 > 64) ? 64 : 4 * COORD_BITS + 8;
  localparam int MAW   = 2 * N + 2;
  localparam int MBW   = 2 * N;
  localparam int PW    = (4 * N + 2 > DEC_W) ? 4 * N + 2 : DEC_W;
  localparam int PXW   = 3 * N;
  localparam int KW    = 2 * N + 5;

  // geometry
  logic [N-1:0]     cx_r, cy_r, x_r, y_r, a2_r, b2_r;
  logic             horiz_r;
  logic             active_r, r2_r;
  // products and decision
  logic [2*N-1:0]   aa_r, bb_r;
  logic [PXW-1:0]   pxb_r, pya_r;
  logic [PXW:0]     diff_r;
  logic [MAW-1:0]   sq_r;
  logic [DEC_W-1:0] t1_r, t2_r, aabb_r, dec_r;
  logic [KW-1:0]    k_r1n_r, k_r1p_r, k_r2n_r, k_r2p_r;

  // load decode
  logic [N-1:0] dx, dy, long_ax, short_ax, y_start;
  logic [N:0]   sum_x, sum_y;
  logic         horiz_ld;

  assign dx       = (corner_start_x >= corner_end_x) ? corner_start_x - corner_end_x
                                                     : corner_end_x - corner_start_x;
  assign dy       = (corner_start_y >= corner_end_y) ? corner_start_y - corner_end_y
                                                     : corner_end_y - corner_start_y;
  assign sum_x    = {1'b0, corner_start_x} + {1'b0, corner_end_x};
  assign sum_y    = {1'b0, corner_start_y} + {1'b0, corner_end_y};
  assign horiz_ld = (dx >= dy);
  assign long_ax  = horiz_ld ? dx : dy;
  assign short_ax = horiz_ld ? dy : dx;
  assign y_start  = {1'b0, short_ax[N-1:1]};

  // shared multiplier operand select
  logic [N:0]     tx;
  logic [N-1:0]   ty;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW-1:0]  prod;

  assign tx = {x_r, 1'b1};
  assign ty = y_r - N'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_AA:   begin mul_a = MAW'(a2_r); mul_b = MBW'(a2_r); end
      OP_BB:   begin mul_a = MAW'(b2_r); mul_b = MBW'(b2_r); end
      OP_AAB2: begin mul_a = MAW'(aa_r); mul_b = MBW'(b2_r); end
      OP_INIT: begin mul_a = MAW'(aa_r); mul_b = bb_r;       end
      OP_XB:   begin mul_a = MAW'(x_r);  mul_b = bb_r;       end
      OP_YA:   begin mul_a = MAW'(y_r);  mul_b = aa_r;       end
      OP_TXSQ: begin mul_a = MAW'(tx);   mul_b = MBW'(tx);   end
      OP_T1:   begin mul_a = sq_r;       mul_b = bb_r;       end
      OP_TYSQ: begin mul_a = MAW'(ty);   mul_b = MBW'(ty);   end
      OP_T2:   begin mul_a = sq_r;       mul_b = aa_r;       end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // step constants, formed once per ellipse
  logic [KW-1:0] bb8, bb4, aa8, aa4;
  assign bb8 = KW'({bb_r, 3'b000});
  assign bb4 = KW'({bb_r, 2'b00});
  assign aa8 = KW'({aa_r, 3'b000});
  assign aa4 = KW'({aa_r, 2'b00});

  // decision variable updates
  logic [DEC_W-1:0] xb8, ya8, diff_ext, diff8;
  logic [DEC_W-1:0] dec_init, dec_ent, dec_r1, dec_r2;
  logic             dec_neg, dec_nonpos;

  assign dec_neg    = dec_r[DEC_W-1];
  assign dec_nonpos = dec_neg || (dec_r == '0);
  assign xb8        = DEC_W'({pxb_r, 3'b000});
  assign ya8        = DEC_W'({pya_r, 3'b000});
  assign diff_ext   = {{(DEC_W - PXW - 1){diff_r[PXW]}}, diff_r};
  assign diff8      = {diff_ext[DEC_W-4:0], 3'b000};

  assign dec_init = DEC_W'({bb_r, 2'b00}) - {t1_r[DEC_W-2:0], 1'b0} + DEC_W'(aa_r);
  assign dec_ent  = t1_r + {t2_r[DEC_W-3:0], 2'b00} - aabb_r;
  assign dec_r1   = dec_neg ? dec_r + xb8 + DEC_W'(k_r1n_r)
                            : dec_r + diff8 + DEC_W'(k_r1p_r);
  assign dec_r2   = dec_nonpos ? dec_r + diff8 + DEC_W'(k_r2n_r)
                               : dec_r - ya8 + DEC_W'(k_r2p_r);

  // next point
  logic [N-1:0] x_nxt, y_nxt;
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (op == OP_R1) begin
      x_nxt = x_r + N'(1);
      y_nxt = dec_neg ? y_r : y_r - N'(1);
    end else if (op == OP_R2) begin
      x_nxt = dec_nonpos ? x_r + N'(1) : x_r;
      y_nxt = y_r - N'(1);
    end
  end

  // outline phase flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      r2_r     <= 1'b0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          active_r <= (y_start != '0);
          r2_r     <= 1'b0;
        end
        OP_ENT:       r2_r     <= 1'b1;
        OP_R1, OP_R2: active_r <= (y_nxt != '0);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        cx_r    <= sum_x[N:1];
        cy_r    <= sum_y[N:1];
        horiz_r <= horiz_ld;
        a2_r    <= long_ax;
        b2_r    <= short_ax;
        x_r     <= '0;
        y_r     <= y_start;
      end
      OP_AA:   aa_r <= prod[2*N-1:0];
      OP_BB:   bb_r <= prod[2*N-1:0];
      OP_AAB2: t1_r <= prod[DEC_W-1:0];
      OP_INIT: begin
        aabb_r  <= prod[DEC_W-1:0];
        dec_r   <= dec_init;
        k_r1n_r <= bb8 + bb4;
        k_r1p_r <= aa8 + bb8 + bb4;
        k_r2n_r <= bb8 + aa8 + aa4;
        k_r2p_r <= aa8 + aa4;
      end
      OP_XB:   pxb_r  <= prod[PXW-1:0];
      OP_YA:   pya_r  <= prod[PXW-1:0];
      OP_CMP:  diff_r <= {1'b0, pxb_r} - {1'b0, pya_r};
      OP_TXSQ: sq_r   <= prod[MAW-1:0];
      OP_T1:   t1_r   <= prod[DEC_W-1:0];
      OP_TYSQ: sq_r   <= prod[MAW-1:0];
      OP_T2:   t2_r   <= prod[DEC_W-1:0];
      OP_ENT:  dec_r  <= dec_ent;
      OP_R1: begin
        dec_r <= dec_r1;
        x_r   <= x_nxt;
        y_r   <= y_nxt;
      end
      OP_R2: begin
        dec_r <= dec_r2;
        x_r   <= x_nxt;
        y_r   <= y_nxt;
      end
      default: ;
    endcase
  end

  // status
  assign sts.active = active_r;
  assign sts.r2     = r2_r;
  assign sts.x_lt   = (pxb_r < pya_r);

  // four-way mirror, axes swapped for a vertical long axis
  logic [N-1:0] u, v;
  assign u        = horiz_r ? x_r : y_r;
  assign v        = horiz_r ? y_r : x_r;
  assign point0_x = cx_r + u;
  assign point0_y = cy_r + v;
  assign point1_x = cx_r - u;
  assign point1_y = cy_r + v;
  assign point2_x = cx_r + u;
  assign point2_y = cy_r - v;
  assign point3_x = cx_r - u;
  assign point3_y = cy_r - v;
  assign last     = (y_r == '0);

  `MER_ASSERT(a_act_y, active_r |-> (y_r != '0), "outline active with y at zero")
  `MER_ASSERT(a_r1_phase, (op == OP_R1) |-> (active_r && !r2_r), "region 1 step outside region 1")
  `MER_ASSERT(a_r2_phase, (op == OP_R2) |-> (active_r && r2_r), "region 2 step outside region 2")

endmodule
